/* rtl/core/phf_pkg.sv */
// ----------------------------------------------------------------------------
// phf_pkg
// Shared types, constants and helpers for the packet header formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package phf_pkg;

  localparam int MAX_HDR_SYMBOLS = 64;
  localparam int CNT_W           = $clog2(MAX_HDR_SYMBOLS + 1);
  localparam int WIDTH_W         = 4;
  localparam int MAX_SYM_BITS    = 8;
  localparam int LEN_W           = 12;
  localparam int CRC_W           = 8;
  localparam int OFF_W           = 5;
  localparam int CFG_DATA_W      = 7;
  localparam int CFG_ADDR_W      = 1;
  localparam int CRC_STAGES      = 4;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;
  localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;

  localparam logic [CNT_W-1:0]   HDR_SYMBOLS_RST = 7'd32;
  localparam logic [WIDTH_W-1:0] SYM_BITS_RST    = 4'd1;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEADER_SYMBOLS  = 1'b0,
    REG_BITS_PER_SYMBOL = 1'b1
  } reg_idx_t;

  // header field being sliced
  typedef enum logic [1:0] {
    FLD_LEN = 2'd0,
    FLD_NUM = 2'd1,
    FLD_CRC = 2'd2,
    FLD_PAD = 2'd3
  } fld_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc;
    logic [LEN_W-1:0] num;
    logic [LEN_W-1:0] len;
  } hdr_desc_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [WIDTH_W-1:0] width;
  } fmt_cfg_t;

  function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] r;
    r = raw;
    if (raw == '0) begin
      r = CNT_W'(1);
    end else if (raw > CNT_W'(MAX_HDR_SYMBOLS)) begin
      r = CNT_W'(MAX_HDR_SYMBOLS);
    end
    return r;
  endfunction

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] raw);
    logic [WIDTH_W-1:0] r;
    r = raw;
    if (raw == '0) begin
      r = WIDTH_W'(1);
    end else if (raw > WIDTH_W'(MAX_SYM_BITS)) begin
      r = WIDTH_W'(MAX_SYM_BITS);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/phf_front.sv */
// ----------------------------------------------------------------------------
// phf_front
// Accepts packet lengths, numbers them and runs the CRC one byte per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module phf_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_len,
  output logic                    push,
  output phf_pkg::hdr_desc_t      push_data,
  input  wire logic               push_ready
);

  phf_pkg::hdr_desc_t st_r   [phf_pkg::CRC_STAGES];
  phf_pkg::hdr_desc_t st_nxt [phf_pkg::CRC_STAGES];
  logic [phf_pkg::CRC_STAGES-1:0] v_r, v_nxt;
  logic [phf_pkg::LEN_W-1:0] ctr_r, ctr_nxt;
  logic en;
  logic acc;

  assign en        = !v_r[phf_pkg::CRC_STAGES-1] || push_ready;
  assign in_ready  = en;
  assign acc       = in_valid && en;
  assign push      = v_r[phf_pkg::CRC_STAGES-1] && push_ready;
  assign push_data = st_r[phf_pkg::CRC_STAGES-1];

  always_comb begin
    st_nxt  = st_r;
    v_nxt   = v_r;
    ctr_nxt = ctr_r;
    if (acc) begin
      ctr_nxt = ctr_r + 1'b1;
    end
    if (en) begin
      v_nxt = {v_r[phf_pkg::CRC_STAGES-2:0], acc};
      st_nxt[0].len = in_len[phf_pkg::LEN_W-1:0];
      st_nxt[0].num = ctr_r;
      st_nxt[0].crc = phf_pkg::crc8_byte(phf_pkg::CRC_INIT, in_len[7:0]);
      // bytes go len_lo, len_hi, num_lo, num_hi
      st_nxt[1]     = st_r[0];
      st_nxt[1].crc = phf_pkg::crc8_byte(st_r[0].crc, {4'b0, st_r[0].len[11:8]});
      st_nxt[2]     = st_r[1];
      st_nxt[2].crc = phf_pkg::crc8_byte(st_r[1].crc, st_r[1].num[7:0]);
      st_nxt[3]     = st_r[2];
      st_nxt[3].crc = phf_pkg::crc8_byte(st_r[2].crc, {4'b0, st_r[2].num[11:8]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      ctr_r <= '0;
    end else begin
      v_r   <= v_nxt;
      ctr_r <= ctr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ctr_r == phf_pkg::LEN_W'($past(ctr_r) + 1'b1))
    else $error("header number did not advance by one on transfer");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[phf_pkg::CRC_STAGES-1] && !push_ready |=>
      v_r[phf_pkg::CRC_STAGES-1] &&
      st_r[phf_pkg::CRC_STAGES-1] == $past(st_r[phf_pkg::CRC_STAGES-1]))
    else $error("last crc stage lost its descriptor while the queue was full");

endmodule

`default_nettype wire

/* rtl/core/phf_queue.sv */
// ----------------------------------------------------------------------------
// phf_queue
// Short descriptor queue between the crc front end and the symbol back end.
// ----------------------------------------------------------------------------
`default_nettype none

module phf_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  phf_pkg::hdr_desc_t      push_data,
  output logic                    push_ready,
  output logic                    pop_valid,
  output phf_pkg::hdr_desc_t      pop_data,
  input  wire logic               pop
);

  phf_pkg::hdr_desc_t mem_r [phf_pkg::QDEPTH];
  logic [phf_pkg::QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [phf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_r];
  // a slot frees up in the same cycle as a pop
  assign push_ready = (cnt_r != phf_pkg::QCNT_W'(phf_pkg::QDEPTH)) || pop;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == phf_pkg::QPTR_W'(phf_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == phf_pkg::QPTR_W'(phf_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("descriptor queue popped while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("descriptor queue pushed while full");

endmodule

`default_nettype wire

/* rtl/core/phf_back.sv */
// ----------------------------------------------------------------------------
// phf_back
// Slices the queued header fields into symbols, one per cycle while a header is queued and out_ready allows.
// ----------------------------------------------------------------------------
`default_nettype none

module phf_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  phf_pkg::fmt_cfg_t       cfg,
  input  wire logic               q_valid,
  input  phf_pkg::hdr_desc_t      q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_symbol,
  output logic                    out_last
);

  logic [phf_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic [phf_pkg::OFF_W-1:0] off_r, off_nxt;
  phf_pkg::fld_t             fld_r, fld_nxt;
  logic                      ov_r, ov_nxt;
  logic [7:0]                sym_r, sym_nxt;
  logic                      last_r, last_nxt;

  logic                      adv, emit, is_last;
  logic [phf_pkg::LEN_W-1:0] val;
  logic [phf_pkg::OFF_W-1:0] nbits;
  logic [phf_pkg::OFF_W-1:0] off_sum;
  logic [8:0]                mask9;
  logic [phf_pkg::LEN_W-1:0] shifted;

  assign adv      = !ov_r || out_ready;
  assign emit     = adv && q_valid;
  assign is_last  = phf_pkg::CNT_W'(pos_r + 1'b1) == cfg.count;
  assign q_pop    = emit && is_last;
  assign mask9    = 9'((9'd1 << cfg.width) - 9'd1);
  assign off_sum  = off_r + phf_pkg::OFF_W'(cfg.width);
  assign shifted  = val >> off_r;

  always_comb begin
    case (fld_r)
      phf_pkg::FLD_LEN: begin
        val   = q_data.len;
        nbits = phf_pkg::OFF_W'(phf_pkg::LEN_W);
      end
      phf_pkg::FLD_NUM: begin
        val   = q_data.num;
        nbits = phf_pkg::OFF_W'(phf_pkg::LEN_W);
      end
      phf_pkg::FLD_CRC: begin
        val   = phf_pkg::LEN_W'(q_data.crc);
        nbits = phf_pkg::OFF_W'(phf_pkg::CRC_W);
      end
      default: begin
        val   = '0;
        nbits = phf_pkg::OFF_W'(phf_pkg::LEN_W);
      end
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    off_nxt  = off_r;
    fld_nxt  = fld_r;
    ov_nxt   = ov_r;
    sym_nxt  = sym_r;
    last_nxt = last_r;
    if (emit) begin
      ov_nxt   = 1'b1;
      sym_nxt  = shifted[7:0] & mask9[7:0];
      last_nxt = is_last;
      if (is_last) begin
        pos_nxt = '0;
        off_nxt = '0;
        fld_nxt = phf_pkg::FLD_LEN;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (off_sum >= nbits) begin
          off_nxt = '0;
          case (fld_r)
            phf_pkg::FLD_LEN: fld_nxt = phf_pkg::FLD_NUM;
            phf_pkg::FLD_NUM: fld_nxt = phf_pkg::FLD_CRC;
            default:          fld_nxt = phf_pkg::FLD_PAD;
          endcase
        end else begin
          off_nxt = off_sum;
        end
      end
    end else if (adv) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      off_r <= '0;
      fld_r <= phf_pkg::FLD_LEN;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      off_r <= off_nxt;
      fld_r <= fld_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
  end

  assign out_valid  = ov_r;
  assign out_symbol = sym_r;
  assign out_last   = last_r;

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> pos_r == '0 && off_r == '0 && fld_r == phf_pkg::FLD_LEN)
    else $error("slicer did not restart after the final symbol");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> pos_r < cfg.count)
    else $error("symbol position ran past the header length");

endmodule

`default_nettype wire

/* rtl/core/packet_header_formatter_core.sv */
// ----------------------------------------------------------------------------
// packet_header_formatter_core
// Builds a crc-8 protected header (length, header number, crc) per length.
// ----------------------------------------------------------------------------
// path: an input passes the 4 crc stage registers, the queue and the output symbol register
// throughput: one symbol per cycle while out_tready is high and a header is queued;
// a header is header_symbols symbols long (default 32), and the 4-stage crc front end
// and 2-entry queue hide the gap between headers
// reset: synchronous active-low; header number clears to 0, header_symbols to 32,
// bits_per_symbol to 1, and all queued or in-flight headers are dropped
`default_nettype none

module packet_header_formatter_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [15:0]                       in_tdata,   // [15:0] packet_length
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [7:0]                             out_tdata,  // [7:0] symbol
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [phf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [phf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [phf_pkg::CNT_W-1:0]   hdr_syms_r;
  logic [phf_pkg::WIDTH_W-1:0] sym_bits_r;
  phf_pkg::fmt_cfg_t           cfg;

  logic                        push, push_ready, q_valid, q_pop;
  phf_pkg::hdr_desc_t          push_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_syms_r <= phf_pkg::HDR_SYMBOLS_RST;
      sym_bits_r <= phf_pkg::SYM_BITS_RST;
    end else if (cfg_we) begin
      case (phf_pkg::reg_idx_t'(cfg_addr))
        phf_pkg::REG_HEADER_SYMBOLS:  hdr_syms_r <= cfg_wdata[phf_pkg::CNT_W-1:0];
        phf_pkg::REG_BITS_PER_SYMBOL: sym_bits_r <= cfg_wdata[phf_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.count = phf_pkg::clamp_count(hdr_syms_r);
  assign cfg.width = phf_pkg::clamp_width(sym_bits_r);

  phf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_len     (in_tdata),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  phf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  phf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_symbol (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire
